>>> design/udmc_pkg.sv
package udmc_pkg;

    // divide widths
    localparam logic [6:0] WIDTH_32 = 7'd32;
    localparam logic [6:0] WIDTH_64 = 7'd64;

    // highest dividend bit index the divider walks through
    localparam logic [7:0] DIV_TOP_BIT = 8'd129;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_COUNT,
        ST_DIV_LO,
        ST_DIV_HI,
        ST_REDUCE,
        ST_STRIP,
        ST_FINISH
    } state_t;

    // start of one division of (2^pa + 2^pc) by the divisor
    typedef struct packed {
        logic       start;
        logic [7:0] pa;
        logic [7:0] pc;
    } div_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] quot;
    } div_rsp_t;

endpackage

>>> design/udmc_div.sv
module udmc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  udmc_pkg::div_req_t req,
    input  logic [63:0]       divisor,
    output udmc_pkg::div_rsp_t rsp
);
    import udmc_pkg::*;

    logic         busy_reg;
    logic         done_reg;
    logic [7:0]   idx_reg;
    logic [7:0]   pa_reg;
    logic [7:0]   pc_reg;
    logic [63:0]  rem_reg;
    logic [127:0] quot_reg;

    logic         dbit;
    logic [64:0]  rem_sh;
    logic         take;
    logic [64:0]  rem_sub;

    // dividend bit at the current index: one power, or two equal ones
    always_comb
    begin
        if (pa_reg == pc_reg)
        begin
            dbit = (idx_reg == pa_reg + 8'd1);
        end
        else
        begin
            dbit = (idx_reg == pa_reg) || (idx_reg == pc_reg);
        end
        rem_sh  = {rem_reg, dbit};
        take    = (rem_sh >= {1'b0, divisor});
        rem_sub = rem_sh - {1'b0, divisor};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (idx_reg == 8'd0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            idx_reg  <= DIV_TOP_BIT;
            pa_reg   <= req.pa;
            pc_reg   <= req.pc;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            idx_reg  <= idx_reg - 8'd1;
            rem_reg  <= take ? rem_sub[63:0] : rem_sh[63:0];
            quot_reg <= {quot_reg[126:0], take};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

>>> design/unsigned_div_magic_coefficients.sv
// channel  direction  handshake                 payload
// input    in         in_valid / in_stall       mode, divisor
// output   out        out_valid / out_stall     pre_shift, multiplier, post_shift,
//                                               add_variant, invalid
//
// one selection pass, from the accepting edge to the result in the output
// register: check, bit count, two 130-step restoring divisions on the shared
// one-bit-per-cycle divider, reduction and finish; the even-divisor retry adds
// trailing-zero stripping and a second pass
// a rejected divisor goes from the check state straight to finish, then to the output register
// in_stall is high from acceptance until the result is in the output register
// the output register holds a result until taken; a new beat can be accepted meanwhile
// rst_n clears the sequencer and output valid asynchronously
module unsigned_div_magic_coefficients (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [63:0] divisor,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  pre_shift,
    output logic [63:0] multiplier,
    output logic [6:0]  post_shift,
    output logic        add_variant,
    output logic        invalid
);
    import udmc_pkg::*;

    state_t       state_reg, state_next;
    logic         pass2_reg, pass2_next;
    logic         out_valid_reg, out_valid_next;

    logic         mode_reg, mode_next;
    logic [63:0]  d_reg, d_next;
    logic [63:0]  t_reg, t_next;
    logic [6:0]   b_reg, b_next;
    logic [6:0]   prec_reg, prec_next;
    logic [5:0]   pre_reg, pre_next;
    logic [6:0]   sh_reg, sh_next;
    logic [127:0] lo_reg, lo_next;
    logic [127:0] hi_reg, hi_next;
    logic [63:0]  res_mult_reg, res_mult_next;
    logic         res_high_reg, res_high_next;
    logic         res_inv_reg, res_inv_next;

    logic [5:0]   out_pre_reg, out_pre_next;
    logic [63:0]  out_mult_reg, out_mult_next;
    logic [6:0]   out_post_reg, out_post_next;
    logic         out_add_reg, out_add_next;
    logic         out_inv_reg, out_inv_next;

    div_req_t     req;
    div_rsp_t     rsp;

    logic [6:0]   width_n;
    logic [7:0]   nb;
    logic [63:0]  d_dec;
    logic         bad_div;
    logic         keep_halving;
    logic [63:0]  sel_mult;
    logic         sel_high;

    // shared restoring divider, one quotient bit per cycle
    udmc_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .divisor (d_reg),
        .rsp     (rsp)
    );

    always_comb
    begin
        width_n = mode_reg ? WIDTH_64 : WIDTH_32;
        nb      = {1'b0, width_n} + {1'b0, b_reg};
        d_dec   = d_reg - 64'd1;
        // zero, one, power of two, or too wide for the 32-bit mode
        bad_div = ((d_reg & d_dec) == 64'd0) || (d_reg == 64'd1)
                  || (!mode_reg && (d_reg[63:32] != 32'd0));
        // keep halving while mlow/2 < mhigh/2
        keep_halving = (sh_reg != 7'd0) && (lo_reg[127:1] < hi_reg[127:1]);
        if (mode_reg)
        begin
            sel_mult = hi_reg[63:0];
            sel_high = hi_reg[64];
        end
        else
        begin
            sel_mult = {32'd0, hi_reg[31:0]};
            sel_high = hi_reg[32];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pass2_next     = pass2_reg;
        mode_next      = mode_reg;
        d_next         = d_reg;
        t_next         = t_reg;
        b_next         = b_reg;
        prec_next      = prec_reg;
        pre_next       = pre_reg;
        sh_next        = sh_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        res_mult_next  = res_mult_reg;
        res_high_next  = res_high_reg;
        res_inv_next   = res_inv_reg;
        out_pre_next   = out_pre_reg;
        out_mult_next  = out_mult_reg;
        out_post_next  = out_post_reg;
        out_add_next   = out_add_reg;
        out_inv_next   = out_inv_reg;
        req            = '0;

        // output beat taken
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode;
                    d_next     = divisor;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                pre_next   = 6'd0;
                pass2_next = 1'b0;
                prec_next  = width_n;
                if (bad_div)
                begin
                    sh_next       = 7'd0;
                    res_mult_next = 64'd0;
                    res_high_next = 1'b0;
                    res_inv_next  = 1'b1;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    res_inv_next = 1'b0;
                    t_next       = d_reg;
                    b_next       = 7'd0;
                    state_next   = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                // bit length of the divisor, one bit a cycle
                if (t_reg != 64'd0)
                begin
                    t_next = {1'b0, t_reg[63:1]};
                    b_next = b_reg + 7'd1;
                end
                else
                begin
                    // mlow = 2^(n+b) / d, formed as two equal powers n+b-1
                    req.start  = 1'b1;
                    req.pa     = nb - 8'd1;
                    req.pc     = nb - 8'd1;
                    state_next = ST_DIV_LO;
                end
            end
            ST_DIV_LO:
            begin
                if (rsp.done)
                begin
                    lo_next    = rsp.quot;
                    // mhigh = (2^(n+b) + 2^(n+b-prec)) / d
                    req.start  = 1'b1;
                    req.pa     = nb;
                    req.pc     = nb - {1'b0, prec_reg};
                    state_next = ST_DIV_HI;
                end
            end
            ST_DIV_HI:
            begin
                if (rsp.done)
                begin
                    hi_next    = rsp.quot;
                    sh_next    = b_reg;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (keep_halving)
                begin
                    lo_next = {1'b0, lo_reg[127:1]};
                    hi_next = {1'b0, hi_reg[127:1]};
                    sh_next = sh_reg - 7'd1;
                end
                else
                begin
                    res_mult_next = sel_mult;
                    res_high_next = sel_high;
                    if (!pass2_reg && sel_high && !d_reg[0])
                    begin
                        state_next = ST_STRIP;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_STRIP:
            begin
                // trailing zeros of an even divisor become the pre-shift
                if (!d_reg[0])
                begin
                    d_next   = {1'b0, d_reg[63:1]};
                    pre_next = pre_reg + 6'd1;
                end
                else
                begin
                    prec_next  = width_n - {1'b0, pre_reg};
                    pass2_next = 1'b1;
                    t_next     = d_reg;
                    b_next     = 7'd0;
                    state_next = ST_COUNT;
                end
            end
            ST_FINISH:
            begin
                // wait for a free output register
                if (!out_valid_reg || !out_stall)
                begin
                    out_pre_next   = pre_reg;
                    out_mult_next  = res_mult_reg;
                    out_post_next  = sh_reg;
                    out_add_next   = res_high_reg;
                    out_inv_next   = res_inv_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass2_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass2_reg     <= pass2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        d_reg        <= d_next;
        t_reg        <= t_next;
        b_reg        <= b_next;
        prec_reg     <= prec_next;
        pre_reg      <= pre_next;
        sh_reg       <= sh_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        res_mult_reg <= res_mult_next;
        res_high_reg <= res_high_next;
        res_inv_reg  <= res_inv_next;
        out_pre_reg  <= out_pre_next;
        out_mult_reg <= out_mult_next;
        out_post_reg <= out_post_next;
        out_add_reg  <= out_add_next;
        out_inv_reg  <= out_inv_next;
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign pre_shift   = out_pre_reg;
    assign multiplier  = out_mult_reg;
    assign post_shift  = out_post_reg;
    assign add_variant = out_add_reg;
    assign invalid     = out_inv_reg;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import udmc_pkg::*;

    // mode codes on the input port
    localparam logic MODE_32 = 1'b0;
    localparam logic MODE_64 = 1'b1;

    // per-cycle idle chance, in percent, on either side
    localparam int IDLE_PCT = 11;

    // random beats after the directed table
    localparam int RANDOM_BEATS = 825;

    // both sides stop idling for this range of random beats
    localparam int CALM_FIRST = 300;
    localparam int CALM_LAST  = 400;

    // long receiver hold-off, counted in clock cycles from the start
    localparam int HOLD_START  = 15000;
    localparam int HOLD_CYCLES = 4000;

    // quiet cycles after the last result, well above one worst-case beat
    localparam int DRAIN_CYCLES = 1000;

    // one result beat, fields in port order
    typedef struct packed {
        logic [5:0]  pre_shift;
        logic [63:0] multiplier;
        logic [6:0]  post_shift;
        logic        add_variant;
        logic        invalid;
    } coeff_t;

    // one directed stimulus row; want is used only when typed is set
    typedef struct {
        logic        mode;
        logic [63:0] divisor;
        logic        typed;
        coeff_t      want;
    } stim_row_t;

    // zero, one, powers of two and over-wide divisors all come back like this
    localparam coeff_t REJECTED = '{6'd0, 64'd0, 7'd0, 1'b0, 1'b1};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic [63:0] divisor;
    logic        out_valid;
    logic        out_stall;
    logic [5:0]  pre_shift;
    logic [63:0] multiplier;
    logic [6:0]  post_shift;
    logic        add_variant;
    logic        invalid;

    // hand-typed expectation that travels with the offered beat
    logic        beat_typed;
    coeff_t      beat_want;

    // set while neither side should idle
    logic        calm;

    coeff_t      pending_coeffs[$];
    stim_row_t   directed_rows[$];
    int          errors = 0;

    always #6 clk = ~clk;

    unsigned_div_magic_coefficients u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .divisor     (divisor),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pre_shift   (pre_shift),
        .multiplier  (multiplier),
        .post_shift  (post_shift),
        .add_variant (add_variant),
        .invalid     (invalid)
    );

    // one selection pass: multiplier bits, post-shift and the n+1 bit flag
    // for a divide width, an odd-or-even divisor and a precision
    function automatic void select_multiplier(
        input  int unsigned width,
        input  logic [63:0] d,
        input  int unsigned prec,
        output logic [63:0] mult,
        output logic [6:0]  post,
        output logic        wide
    );
        int unsigned   nbits;
        int            i;
        logic [129:0]  num_lo;
        logic [129:0]  num_hi;
        logic [129:0]  quo;
        logic [127:0]  m_lo;
        logic [127:0]  m_hi;
        nbits = 0;
        for (i = 0; i < 64; i++)
        begin
            if (d[i])
                nbits = i + 1;
        end
        // exact wide quotients of 2^(n+b) and 2^(n+b) + 2^(n+b-prec)
        num_lo = 130'd1 << (width + nbits);
        num_hi = num_lo + (130'd1 << (width + nbits - prec));
        quo    = num_lo / {66'd0, d};
        m_lo   = quo[127:0];
        quo    = num_hi / {66'd0, d};
        m_hi   = quo[127:0];
        post   = nbits[6:0];
        // halve both bounds while they stay apart
        while (post != 7'd0 && (m_lo >> 1) < (m_hi >> 1))
        begin
            m_lo = m_lo >> 1;
            m_hi = m_hi >> 1;
            post = post - 7'd1;
        end
        if (width == 32'(WIDTH_32))
        begin
            mult = {32'd0, m_hi[31:0]};
            wide = m_hi[32];
        end
        else
        begin
            mult = m_hi[63:0];
            wide = m_hi[64];
        end
    endfunction

    // full coefficient set for one input beat
    function automatic coeff_t magic_coeffs(input logic m, input logic [63:0] d);
        coeff_t      res;
        int unsigned width;
        int unsigned pre;
        logic [63:0] odd;
        logic [63:0] mult;
        logic [6:0]  post;
        logic        wide;
        res   = '0;
        width = (m == MODE_64) ? 32'(WIDTH_64) : 32'(WIDTH_32);
        if (d <= 64'd1 || (d & (d - 64'd1)) == 64'd0 || (m == MODE_32 && d > 64'hFFFF_FFFF))
            res.invalid = 1'b1;
        else
        begin
            pre = 0;
            select_multiplier(width, d, width, mult, post, wide);
            // even divisor with an n+1 bit multiplier: pre-shift and retry on the odd part
            if (wide && !d[0])
            begin
                odd = d;
                while (!odd[0])
                begin
                    odd = odd >> 1;
                    pre++;
                end
                select_multiplier(width, odd, width - pre, mult, post, wide);
            end
            res.pre_shift   = pre[5:0];
            res.multiplier  = mult;
            res.post_shift  = post;
            res.add_variant = wide;
        end
        return res;
    endfunction

    // random divisor, mixing the shapes that steer the selection differently
    function automatic logic [63:0] pick_divisor(input logic m);
        logic [63:0] d;
        int          k;
        case ($urandom_range(9))
            0: d = 64'($urandom_range(2, 1000));
            1: d = {$urandom, $urandom};
            2: d = 64'd1 << $urandom_range(63);
            3:
            begin
                // odd part times a power of two, exercises the retry
                k = $urandom_range(1, (m == MODE_64) ? 63 : 31);
                d = $urandom_range(1) ? {$urandom, $urandom} : 64'($urandom_range(1, 999));
                d = (d | 64'd1) << k;
            end
            4:
            begin
                k = $urandom_range(2, 63);
                d = $urandom_range(1) ? (64'd1 << k) + 64'd1 : (64'd1 << k) - 64'd1;
            end
            5: d = ~64'd0 - 64'($urandom_range(0, 1000));
            default: d = {$urandom, $urandom} >> $urandom_range(63);
        endcase
        // keep most 32-bit beats in range, leave a few over-wide
        if (m == MODE_32 && $urandom_range(9) != 0)
            d = {32'd0, d[31:0]};
        return d;
    endfunction

    task automatic add_row(input logic m, input logic [63:0] d, input logic typed,
                           input coeff_t want);
        stim_row_t row;
        row.mode    = m;
        row.divisor = d;
        row.typed   = typed;
        row.want    = want;
        directed_rows.push_back(row);
    endtask

    // offer one beat and hold it until taken; gaps only while not calm
    task automatic send_beat(input logic m, input logic [63:0] d, input logic typed,
                             input coeff_t want, input logic no_gaps);
        if (!no_gaps)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid   <= 1'b1;
        mode       <= m;
        divisor    <= d;
        beat_typed <= typed;
        beat_want  <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // expectation on every input beat, comparison on every output beat
    always @(posedge clk)
    begin : scoreboard
        coeff_t want;
        if (rst_n && in_valid && !in_stall)
            pending_coeffs.push_back(beat_typed ? beat_want : magic_coeffs(mode, divisor));
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_coeffs.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                want = pending_coeffs.pop_front();
                if (pre_shift !== want.pre_shift)
                begin
                    $error("pre_shift: expected %0d, got %0d", want.pre_shift, pre_shift);
                    errors++;
                end
                if (multiplier !== want.multiplier)
                begin
                    $error("multiplier: expected %h, got %h", want.multiplier, multiplier);
                    errors++;
                end
                if (post_shift !== want.post_shift)
                begin
                    $error("post_shift: expected %0d, got %0d", want.post_shift, post_shift);
                    errors++;
                end
                if (add_variant !== want.add_variant)
                begin
                    $error("add_variant: expected %0b, got %0b", want.add_variant, add_variant);
                    errors++;
                end
                if (invalid !== want.invalid)
                begin
                    $error("invalid: expected %0b, got %0b", want.invalid, invalid);
                    errors++;
                end
            end
        end
    end

    // receiver: random stalls, one long hold-off so the block backs up, none while calm
    initial
    begin : receiver
        int unsigned cyc;
        cyc = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES)
                out_stall <= 1'b1;
            else if (calm)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial
    begin : stimulus
        int          idx;
        logic        m;
        logic [63:0] d;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        mode       <= MODE_32;
        divisor    <= 64'd0;
        beat_typed <= 1'b0;
        beat_want  <= '0;
        calm       <= 1'b0;

        // rejected divisors: zero, one, powers of two, too wide for 32 bits
        add_row(MODE_32, 64'd0, 1'b1, REJECTED);
        add_row(MODE_32, 64'd1, 1'b1, REJECTED);
        add_row(MODE_64, 64'd0, 1'b1, REJECTED);
        add_row(MODE_64, 64'd1, 1'b1, REJECTED);
        add_row(MODE_32, 64'd2, 1'b1, REJECTED);
        add_row(MODE_32, 64'h8000_0000, 1'b1, REJECTED);
        add_row(MODE_64, 64'h8000_0000_0000_0000, 1'b1, REJECTED);
        add_row(MODE_64, 64'd1 << 40, 1'b1, REJECTED);
        add_row(MODE_32, 64'h1_0000_0001, 1'b1, REJECTED);
        add_row(MODE_32, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, REJECTED);
        // textbook coefficients: divide by 3 fits, divide by 7 needs the add sequence
        add_row(MODE_32, 64'd3, 1'b1, '{6'd0, 64'hAAAA_AAAB, 7'd1, 1'b0, 1'b0});
        add_row(MODE_32, 64'd7, 1'b1, '{6'd0, 64'h2492_4925, 7'd3, 1'b1, 1'b0});
        add_row(MODE_64, 64'd3, 1'b1, '{6'd0, 64'hAAAA_AAAA_AAAA_AAAB, 7'd1, 1'b0, 1'b0});
        // predictor-checked: small, even retry, top of range in both widths
        add_row(MODE_64, 64'd7, 1'b0, '0);
        add_row(MODE_32, 64'd5, 1'b0, '0);
        add_row(MODE_32, 64'd14, 1'b0, '0);
        add_row(MODE_64, 64'd10, 1'b0, '0);
        add_row(MODE_32, 64'hFFFF_FFFF, 1'b0, '0);
        add_row(MODE_32, 64'h8000_0001, 1'b0, '0);
        add_row(MODE_32, 64'hFFFF_FFFE, 1'b0, '0);
        add_row(MODE_32, 64'hC000_0000, 1'b0, '0);
        add_row(MODE_64, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0);
        add_row(MODE_64, 64'h8000_0000_0000_0001, 1'b0, '0);
        add_row(MODE_64, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, '0);
        add_row(MODE_64, 64'hC000_0000_0000_0000, 1'b0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].mode, directed_rows[i].divisor,
                      directed_rows[i].typed, directed_rows[i].want, 1'b0);

        for (idx = 0; idx < RANDOM_BEATS; idx++)
        begin
            m = $urandom_range(1);
            d = pick_divisor(m);
            calm <= (idx >= CALM_FIRST && idx < CALM_LAST);
            send_beat(m, d, 1'b0, '0, (idx >= CALM_FIRST && idx < CALM_LAST));
        end
        in_valid <= 1'b0;
        calm     <= 1'b0;

        // let the scoreboard log the last accepted beat before checking the queue
        @(posedge clk);

        // drain, then watch for stray beats
        while (pending_coeffs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial
    begin : watchdog
        #(64'd60_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule
